@@ rtl/smpq_pkg.sv @@
// smpq_pkg: sizes, request and status codes, and cell control struct for the
// stable minimum priority queue. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package smpq_pkg;

    localparam int CAPACITY    = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int PRIO_WIDTH  = 16;
    localparam int COUNT_WIDTH = $clog2(CAPACITY + 1);

    typedef logic [VALUE_WIDTH-1:0] value_t;
    typedef logic [PRIO_WIDTH-1:0]  prio_t;
    typedef logic [COUNT_WIDTH-1:0] count_t;

    localparam logic REQ_ENQ = 1'b0;
    localparam logic REQ_DEQ = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // Broadcast to every cell; at most one is set in a cycle.
    typedef struct packed {
        logic enq;
        logic deq;
    } cell_ctrl_t;

endpackage
`default_nettype wire

@@ rtl/smpq_cell.sv @@
// smpq_cell: one slot of the sorted chain (value and priority).
// Depends on smpq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module smpq_cell
    import smpq_pkg::*;
(
    input  wire logic       clk,
    input  wire cell_ctrl_t ctrl,
    input  wire value_t     new_value,
    input  wire prio_t      new_prio,
    input  wire logic       occupied,
    input  wire value_t     left_value,
    input  wire prio_t      left_prio,
    input  wire logic       left_after,
    input  wire value_t     right_value,
    input  wire prio_t      right_prio,
    output value_t          value,
    output prio_t           slot_prio,
    output logic            after
);

    value_t value_reg, value_next;
    prio_t  prio_reg, prio_next;

    // New entry goes behind this slot when it holds an equal or smaller priority.
    assign after     = occupied && (prio_reg <= new_prio);
    assign value     = value_reg;
    assign slot_prio = prio_reg;

    always_comb
    begin
        value_next = value_reg;
        prio_next  = prio_reg;
        if (ctrl.enq && !after)
        begin
            if (left_after)
            begin
                value_next = new_value;
                prio_next  = new_prio;
            end
            else
            begin
                value_next = left_value;
                prio_next  = left_prio;
            end
        end
        else if (ctrl.deq)
        begin
            value_next = right_value;
            prio_next  = right_prio;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        prio_reg  <= prio_next;
    end

endmodule
`default_nettype wire

@@ rtl/stable_min_priority_queue.sv @@
// Stable minimum priority queue: top level, a chain of smpq_cell slots plus
// count and result handshake. Depends on smpq_pkg and smpq_cell.
`timescale 1ns / 1ps
`default_nettype none
// Usage
//   Input channel (in_valid / in_stall): one request per transfer. req_type
//   selects enqueue (elem_value, prio) or dequeue of the head.
//   Output channel (out_valid / out_stall): exactly one result per request,
//   giving head value and priority (zero when empty), entry count, empty flag
//   and status (ok, enqueue refused because full, dequeue refused because
//   empty). Equal priorities leave in arrival order.
//   Latency: the result appears the cycle after the request transfer.
//   Throughput: one request per cycle while the receiver keeps taking results.
//   Each slot compares its priority with the incoming one and shifts towards
//   its neighbour, all slots together, so the whole insert or remove is one step.
//   The result is read straight from slot 0 and the count; the queue holds
//   still while a result is pending and stalled, so in_stall is raised then.
//   Reset empties the queue (count to zero) and drops any pending result;
//   slot contents are not cleared, as slots beyond the count are never shown.
module stable_min_priority_queue
    import smpq_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   in_valid,
    output logic        in_stall,
    input  wire logic   req_type,
    input  wire value_t elem_value,
    input  wire prio_t  prio,
    output logic        out_valid,
    input  wire logic   out_stall,
    output value_t      head_value,
    output prio_t       head_prio,
    output count_t      entry_count,
    output logic        queue_empty,
    output logic [1:0]  status
);

    localparam count_t CAP_COUNT = COUNT_WIDTH'(CAPACITY);

    count_t     count_reg, count_next;
    status_t    status_reg, status_next;
    logic       out_valid_reg, out_valid_next;
    logic       in_accept;
    logic       is_full;
    logic       is_empty;
    cell_ctrl_t ctrl;

    value_t cell_value [CAPACITY];
    prio_t  cell_prio  [CAPACITY];
    logic   cell_after [CAPACITY];

    // Hold the queue while a result waits on a stalled receiver.
    assign in_stall  = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;
    assign is_full   = (count_reg == CAP_COUNT);
    assign is_empty  = (count_reg == '0);

    assign ctrl.enq = in_accept && (req_type == REQ_ENQ) && !is_full;
    assign ctrl.deq = in_accept && (req_type == REQ_DEQ) && !is_empty;

    // Sorted chain; slot 0 is the head.
    for (genvar gi = 0; gi < CAPACITY; gi++)
    begin : g_cell
        value_t left_value, right_value;
        prio_t  left_prio, right_prio;
        logic   left_after;

        if (gi == 0)
        begin : g_first
            assign left_value = '0;
            assign left_prio  = '0;
            assign left_after = 1'b1;
        end
        else
        begin : g_inner_left
            assign left_value = cell_value[gi-1];
            assign left_prio  = cell_prio[gi-1];
            assign left_after = cell_after[gi-1];
        end

        if (gi == CAPACITY - 1)
        begin : g_last
            assign right_value = '0;
            assign right_prio  = '0;
        end
        else
        begin : g_inner_right
            assign right_value = cell_value[gi+1];
            assign right_prio  = cell_prio[gi+1];
        end

        smpq_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .new_value   (elem_value),
            .new_prio    (prio),
            .occupied    (count_reg > COUNT_WIDTH'(gi)),
            .left_value  (left_value),
            .left_prio   (left_prio),
            .left_after  (left_after),
            .right_value (right_value),
            .right_prio  (right_prio),
            .value       (cell_value[gi]),
            .slot_prio   (cell_prio[gi]),
            .after       (cell_after[gi])
        );
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.enq)
        begin
            count_next = count_reg + COUNT_WIDTH'(1);
        end
        else if (ctrl.deq)
        begin
            count_next = count_reg - COUNT_WIDTH'(1);
        end
    end

    always_comb
    begin
        status_next    = status_reg;
        out_valid_next = out_valid_reg;
        if (in_accept)
        begin
            out_valid_next = 1'b1;
            case (req_type)
                REQ_ENQ: status_next = is_full  ? ST_FULL  : ST_OK;
                REQ_DEQ: status_next = is_empty ? ST_EMPTY : ST_OK;
                default: status_next = ST_OK;
            endcase
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            status_reg    <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            status_reg    <= status_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign entry_count = count_reg;
    assign queue_empty = is_empty;
    assign head_value  = is_empty ? '0 : cell_value[0];
    assign head_prio   = is_empty ? '0 : cell_prio[0];
    assign status      = status_reg;

endmodule
`default_nettype wire

@@ rtl/smpq_chk.sv @@
// smpq_chk: port-level checks for stable_min_priority_queue, with its bind.
// Depends on smpq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module smpq_chk
    import smpq_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire value_t     head_value,
    input wire prio_t      head_prio,
    input wire count_t     entry_count,
    input wire logic       queue_empty,
    input wire logic [1:0] status
);

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> entry_count <= COUNT_WIDTH'(CAPACITY))
        else $error("entry count beyond capacity");

    a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (queue_empty == (entry_count == '0))
                      && (!queue_empty || (head_value == '0 && head_prio == '0)))
        else $error("empty flag or head fields inconsistent with count");

    a_refusal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_EMPTY |-> queue_empty)
        else $error("dequeue refused while entries held");

    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_FULL |-> entry_count == COUNT_WIDTH'(CAPACITY))
        else $error("enqueue refused while not full");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(head_value)
                                   && $stable(entry_count) && $stable(status))
        else $error("stalled result changed");

endmodule

bind stable_min_priority_queue smpq_chk u_smpq_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .head_value  (head_value),
    .head_prio   (head_prio),
    .entry_count (entry_count),
    .queue_empty (queue_empty),
    .status      (status)
);
`default_nettype wire
